// File: rtl/gpae_pkg.sv
// Package for the glow-curve peak activation energy unit.
// Holds shared widths, codes, fixed-point constants and the controller states.
// No dependencies.
package gpae_pkg;

  // Parameter defaults
  localparam int unsigned DEF_MAX_SAMPLES    = 1024;
  localparam int unsigned DEF_COUNT_BITS     = 24;
  localparam int unsigned DEF_TEMP_FRAC_BITS = 6;

  // Beat field widths
  localparam int unsigned FUNC_W   = 2;
  localparam int unsigned TEMP_W   = 16;
  localparam int unsigned CNT_IN_W = 24;
  localparam int unsigned IDX_W    = 10;
  localparam int unsigned E_W      = 20;
  localparam int unsigned STAT_W   = 2;
  localparam int unsigned LIM_W    = 18;
  localparam int unsigned IN_DATA_W  = 56;
  localparam int unsigned OUT_DATA_W = 56;

  // Operation codes
  localparam logic [FUNC_W-1:0] FUNC_LOAD    = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_ANALYZE = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_RESTART = 2'd2;
  localparam logic [FUNC_W-1:0] FUNC_NOP     = 2'd3;

  // Status codes
  localparam logic [STAT_W-1:0] ST_OK       = 2'd0;
  localparam logic [STAT_W-1:0] ST_NO_PEAK  = 2'd1;
  localparam logic [STAT_W-1:0] ST_NO_HALF  = 2'd2;
  localparam logic [STAT_W-1:0] ST_LEFT_NEG = 2'd3;

  localparam logic [LIM_W-1:0] ENERGY_LIMIT_RST = 18'd196608;

  // Datapath widths
  localparam int unsigned TK_W   = 18;  // Kelvin temperature, unsigned
  localparam int unsigned TD_W   = 17;  // signed temperature differences
  localparam int unsigned DIV_W  = 52;  // divider dividend and quotient
  localparam int unsigned DVS_W  = 27;  // divider divisor
  localparam int unsigned MU_W   = 20;  // signed mu, Q16
  localparam int unsigned CF_W   = 32;  // signed C and b, scaled by 1000, Q16
  localparam int unsigned P_W    = 53;  // signed products and inner term
  localparam int unsigned KP_W   = 45;  // k * TM product
  localparam int unsigned KT_W   = 36;  // kT, Q32 eV
  localparam int unsigned RAT_W  = 28;  // signed ratio, Q16
  localparam int unsigned EP_W   = 65;  // signed kT * ratio
  localparam int unsigned ES_W   = 32;  // signed rounded energy

  localparam logic [26:0] BOLTZ_Q40 = 27'd94748549;
  localparam logic [DIV_W-1:0] MU_LIM    = 52'd262144;
  localparam logic [DIV_W-1:0] RATIO_LIM = 52'd67108864;
  localparam logic signed [39:0] C_BASE = 40'sd16384000;   // (1510 - 1260) * 2^16
  localparam logic signed [39:0] B_BASE = -40'sd12058624;  // (1580 - 1764) * 2^16
  localparam logic signed [39:0] C_MU   = 40'sd3000;
  localparam logic signed [39:0] B_MU   = 40'sd4200;
  localparam logic signed [ES_W-1:0] ENERGY_FLOOR = -32'sd524288;

  typedef enum logic [4:0] {
    S_IDLE, S_PK_RD, S_PK_CHK, S_RT_RD, S_RT_CHK, S_LT_RD, S_LT_CHK,
    S_DIFF, S_MU_DIV, S_MU_WAIT, S_COEF, S_PROD, S_INNER, S_ABS,
    S_RT_DIV, S_RT_WAIT, S_EMUL, S_EABS, S_ERND, S_DONE
  } state_e;

endpackage

// File: rtl/glow_peak_activation_energy_unit.sv
// Glow-curve peak analysis unit: sample store, peak search and peak-shape activation energy.
// Depends on gpae_pkg and gpae_div.
//
// Loads (func 0) and restarts (func 2) are taken in the idle state; a load
// past MAX_SAMPLES is dropped. An analyze beat (func 1) is handled alone: the
// single-port sample memory is scanned with a read and a check state per
// sample, first from index 0 up to the peak and then again from the peak to
// the half-maximum sample, after which the left sample is read. The energy
// then takes two passes through the shared serial divider (each a start, 52
// quotient bits at one bit per cycle and a finish; the mu pass is skipped
// when TR equals TL) and then steps through the product, magnitude and
// rounding states to S_DONE, which hands the beat to the output register.
// A query that ends early (no peak, no half max, negative left index) skips
// the energy part. Loads are taken while a finished result waits on the
// master side.
module glow_peak_activation_energy_unit import gpae_pkg::*; #(
  parameter int unsigned MAX_SAMPLES    = DEF_MAX_SAMPLES,
  parameter int unsigned COUNT_BITS     = DEF_COUNT_BITS,
  parameter int unsigned TEMP_FRAC_BITS = DEF_TEMP_FRAC_BITS
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [LIM_W-1:0]      cfg_wdata_i,    // energy_limit
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  // temperature[15:0], count[39:16], peak_temperature[55:40]
  input  logic [IN_DATA_W-1:0]  s_axis_tdata,
  input  logic [FUNC_W-1:0]     s_axis_tuser,   // func
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  // left_index[9:0], peak_index[19:10], right_index[29:20], energy[49:30],
  // status[51:50], zeros above
  output logic [OUT_DATA_W-1:0] m_axis_tdata
);

  localparam int unsigned AW    = $clog2(MAX_SAMPLES);
  localparam int unsigned LW    = AW + 1;
  localparam int unsigned MEM_W = TEMP_W + COUNT_BITS;
  localparam int unsigned KOFF  = (27315 * (1 << TEMP_FRAC_BITS) + 50) / 100;
  localparam int unsigned KT_SH = 8 + TEMP_FRAC_BITS;

  state_e state_q, state_d;

  logic [LIM_W-1:0] limit_q;
  logic [LW-1:0]    len_q;

  // Sample memory: {temperature, count}
  logic [MEM_W-1:0] mem_q [MAX_SAMPLES];
  logic [MEM_W-1:0] rdata_q;
  logic             rd_en, wr_en;
  logic [TEMP_W-1:0]     rd_temp;
  logic [COUNT_BITS-1:0] rd_cnt;

  logic in_acc;
  logic [TEMP_W-1:0]   in_temp, in_pt;
  logic [CNT_IN_W-1:0] in_cnt;

  // Search registers
  logic [LW-1:0]  idx_q, peak_q, right_q, left_q, idx_nxt, span;
  logic [TEMP_W-1:0] pt_q, tm_q, tr_q, tl_q;
  logic [COUNT_BITS-1:0] pc_q;
  logic [STAT_W-1:0] status_q;
  logic hit, half, too_far;

  // Energy datapath
  logic [TK_W-1:0] tmk_q;
  logic signed [TD_W-1:0] tau_q, tau_raw, delta, omega;
  logic [TD_W-1:0] adelta_q, aomega_q, atau;
  logic omega_zero_q, neg_q;
  logic signed [MU_W-1:0] mu_q;
  logic signed [39:0] mu_x, c_full, b_full;
  logic signed [CF_W-1:0] c_q, b_q;
  logic [KP_W-1:0] kprod_q;
  logic [KT_W-1:0] kt_q;
  logic signed [P_W-1:0] p1_q, p2_q, inner_q;
  logic [DIV_W-1:0] ainner_q;
  logic [DVS_W-1:0] dvs_q;
  logic signed [RAT_W-1:0] ratio_q;
  logic signed [EP_W-1:0] eprod_q;
  logic [EP_W-1:0] emag_q;
  logic [ES_W-1:0] eq;
  logic signed [ES_W-1:0] e_s;
  logic [E_W-1:0] energy_q;
  logic [DIV_W-1:0] mu_mag, rat_mag;

  logic             div_start, div_done;
  logic [DIV_W-1:0] div_dividend, div_quo;
  logic [DVS_W-1:0] div_divisor;

  logic load_out, out_valid_q;
  logic [OUT_DATA_W-1:0] out_data_q;

  assign in_temp = s_axis_tdata[15:0];
  assign in_cnt  = s_axis_tdata[39:16];
  assign in_pt   = s_axis_tdata[55:40];
  assign in_acc  = s_axis_tvalid && s_axis_tready;
  assign wr_en   = in_acc && (s_axis_tuser == FUNC_LOAD) && (len_q < LW'(MAX_SAMPLES));

  assign rd_temp = rdata_q[MEM_W-1:COUNT_BITS];
  assign rd_cnt  = rdata_q[COUNT_BITS-1:0];
  assign idx_nxt = idx_q + 1'b1;
  assign hit     = rd_temp == pt_q;
  assign half    = {rd_cnt, 1'b0} <= {1'b0, pc_q};
  assign span    = idx_q - peak_q;
  assign too_far = span > peak_q;

  // Write at the fill point, read at the scan index
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[len_q[AW-1:0]] <= {in_temp, COUNT_BITS'(in_cnt)};
    end
    if (rd_en) begin
      rdata_q <= mem_q[idx_q[AW-1:0]];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      limit_q     <= ENERGY_LIMIT_RST;
      len_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        limit_q <= cfg_wdata_i;
      end
      if (wr_en) begin
        len_q <= len_q + 1'b1;
      end else if (in_acc && s_axis_tuser == FUNC_RESTART) begin
        len_q <= '0;
      end
      if (load_out) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Controller
  always_comb begin
    state_d       = state_q;
    rd_en         = 1'b0;
    div_start     = 1'b0;
    div_dividend  = ainner_q + DIV_W'(dvs_q >> 1);
    div_divisor   = dvs_q;
    load_out      = 1'b0;
    s_axis_tready = state_q == S_IDLE;
    case (state_q)
      S_IDLE: begin
        if (s_axis_tvalid && s_axis_tuser == FUNC_ANALYZE) begin
          state_d = (len_q == '0) ? S_DONE : S_PK_RD;
        end
      end
      S_PK_RD: begin
        rd_en   = 1'b1;
        state_d = S_PK_CHK;
      end
      S_PK_CHK: begin
        if (hit) state_d = S_RT_RD;
        else if (idx_nxt == len_q) state_d = S_DONE;
        else state_d = S_PK_RD;
      end
      S_RT_RD: begin
        rd_en   = 1'b1;
        state_d = S_RT_CHK;
      end
      S_RT_CHK: begin
        if (half) state_d = too_far ? S_DONE : S_LT_RD;
        else if (idx_nxt == len_q) state_d = S_DONE;
        else state_d = S_RT_RD;
      end
      S_LT_RD: begin
        rd_en   = 1'b1;
        state_d = S_LT_CHK;
      end
      S_LT_CHK: state_d = S_DIFF;
      S_DIFF:   state_d = S_MU_DIV;
      S_MU_DIV: begin
        // mu = delta * 2^16 / omega, rounded half away from zero
        div_dividend = (DIV_W'(adelta_q) << 16) + DIV_W'(aomega_q >> 1);
        div_divisor  = DVS_W'(aomega_q);
        if (omega_zero_q) begin
          state_d = S_COEF;
        end else begin
          div_start = 1'b1;
          state_d   = S_MU_WAIT;
        end
      end
      S_MU_WAIT: if (div_done) state_d = S_COEF;
      S_COEF:    state_d = S_PROD;
      S_PROD:    state_d = S_INNER;
      S_INNER:   state_d = S_ABS;
      S_ABS:     state_d = S_RT_DIV;
      S_RT_DIV: begin
        div_start = 1'b1;
        state_d   = S_RT_WAIT;
      end
      S_RT_WAIT: if (div_done) state_d = S_EMUL;
      S_EMUL:    state_d = S_EABS;
      S_EABS:    state_d = S_ERND;
      S_ERND:    state_d = S_DONE;
      S_DONE: begin
        if (!out_valid_q || m_axis_tready) begin
          load_out = 1'b1;
          state_d  = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  gpae_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dividend),
    .divisor_i  (div_divisor),
    .done_o     (div_done),
    .quotient_o (div_quo)
  );

  assign tau_raw = $signed({1'b0, tm_q}) - $signed({1'b0, tl_q});
  assign delta   = $signed({1'b0, tr_q}) - $signed({1'b0, tm_q});
  assign omega   = $signed({1'b0, tr_q}) - $signed({1'b0, tl_q});
  assign atau    = tau_q[TD_W-1] ? TD_W'(-tau_q) : TD_W'(tau_q);
  assign mu_x    = 40'(mu_q);
  assign c_full  = C_BASE + mu_x * C_MU;
  assign b_full  = B_BASE + mu_x * B_MU;
  assign mu_mag  = (div_quo > MU_LIM) ? MU_LIM : div_quo;
  assign rat_mag = (div_quo > RATIO_LIM) ? RATIO_LIM : div_quo;
  assign eq      = ES_W'((emag_q + (EP_W'(1) << 31)) >> 32);
  assign e_s     = neg_q ? -$signed(eq) : $signed(eq);

  // Datapath: scan bookkeeping and the energy pipeline steps
  always_ff @(posedge clk_i) begin
    case (state_q)
      S_IDLE: begin
        idx_q    <= '0;
        pt_q     <= in_pt;
        status_q <= ST_NO_PEAK;
        peak_q   <= '0;
        right_q  <= '0;
        left_q   <= '0;
        energy_q <= '0;
      end
      S_PK_CHK: begin
        if (hit) begin
          peak_q   <= idx_q;
          pc_q     <= rd_cnt;
          tm_q     <= rd_temp;
          status_q <= ST_NO_HALF;
        end else begin
          idx_q <= idx_nxt;
        end
      end
      S_RT_CHK: begin
        if (half) begin
          right_q <= idx_q;
          tr_q    <= rd_temp;
          if (too_far) begin
            status_q <= ST_LEFT_NEG;
          end else begin
            left_q   <= peak_q - span;
            idx_q    <= peak_q - span;
            status_q <= ST_OK;
          end
        end else begin
          idx_q <= idx_nxt;
        end
      end
      S_LT_CHK: tl_q <= rd_temp;
      S_DIFF: begin
        tmk_q        <= TK_W'(tm_q) + TK_W'(KOFF);
        tau_q        <= (tau_raw == '0) ? TD_W'(1 << TEMP_FRAC_BITS) : tau_raw;
        adelta_q     <= delta[TD_W-1] ? TD_W'(-delta) : TD_W'(delta);
        aomega_q     <= omega[TD_W-1] ? TD_W'(-omega) : TD_W'(omega);
        omega_zero_q <= omega == '0;
        neg_q        <= delta[TD_W-1] ^ omega[TD_W-1];
        mu_q         <= '0;
      end
      S_MU_WAIT: begin
        if (div_done) begin
          mu_q <= neg_q ? -$signed(MU_W'(mu_mag)) : $signed(MU_W'(mu_mag));
        end
      end
      S_COEF: begin
        c_q     <= CF_W'(c_full);
        b_q     <= CF_W'(b_full);
        kprod_q <= KP_W'(BOLTZ_Q40) * KP_W'(tmk_q);
      end
      S_PROD: begin
        p1_q <= P_W'(c_q) * P_W'($signed({1'b0, tmk_q}));
        p2_q <= P_W'(b_q) * P_W'(tau_q);
        kt_q <= KT_W'((kprod_q + (KP_W'(1) << (KT_SH - 1))) >> KT_SH);
      end
      S_INNER: begin
        inner_q <= p1_q - (p2_q <<< 1);
        dvs_q   <= DVS_W'(atau) * DVS_W'(1000);
      end
      S_ABS: begin
        ainner_q <= inner_q[P_W-1] ? DIV_W'(-inner_q) : DIV_W'(inner_q);
        neg_q    <= inner_q[P_W-1] ^ tau_q[TD_W-1];
      end
      S_RT_WAIT: begin
        if (div_done) begin
          ratio_q <= neg_q ? -$signed(RAT_W'(rat_mag)) : $signed(RAT_W'(rat_mag));
        end
      end
      S_EMUL: eprod_q <= EP_W'($signed({1'b0, kt_q})) * EP_W'(ratio_q);
      S_EABS: begin
        emag_q <= eprod_q[EP_W-1] ? EP_W'(-eprod_q) : EP_W'(eprod_q);
        neg_q  <= eprod_q[EP_W-1];
      end
      S_ERND: begin
        // clamp above at the limit, saturate below at -8 eV
        if (e_s > $signed({{(ES_W - LIM_W){1'b0}}, limit_q})) begin
          energy_q <= E_W'(limit_q);
        end else if (e_s < ENERGY_FLOOR) begin
          energy_q <= E_W'(ENERGY_FLOOR);
        end else begin
          energy_q <= E_W'(e_s);
        end
      end
      default: ;
    endcase
  end

  // Output register
  always_ff @(posedge clk_i) begin
    if (load_out) begin
      out_data_q <= {4'b0, status_q, energy_q, IDX_W'(right_q), IDX_W'(peak_q),
                     IDX_W'(left_q)};
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

endmodule

// File: rtl/gpae_div.sv
// Radix-2 restoring divider, one quotient bit per cycle.
// Depends on gpae_pkg for widths.
module gpae_div import gpae_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [DIV_W-1:0] dividend_i,
  input  logic [DVS_W-1:0] divisor_i,
  output logic             done_o,
  output logic [DIV_W-1:0] quotient_o
);

  localparam int unsigned CW = $clog2(DIV_W + 1);

  logic             busy_q, done_q;
  logic [CW-1:0]    cnt_q;
  logic [DVS_W:0]   rem_q, rem_d, shifted;
  logic [DIV_W-1:0] quo_q;
  logic [DVS_W-1:0] dvs_q;
  logic             ge;

  assign shifted = {rem_q[DVS_W-1:0], quo_q[DIV_W-1]};
  assign ge      = shifted >= {1'b0, dvs_q};
  assign rem_d   = ge ? shifted - {1'b0, dvs_q} : shifted;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CW'(DIV_W);
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == CW'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quo_q <= dividend_i;
      rem_q <= '0;
      dvs_q <= divisor_i;
    end else if (busy_q) begin
      rem_q <= rem_d;
      quo_q <= {quo_q[DIV_W-2:0], ge};
    end
  end

  assign done_o     = done_q;
  assign quotient_o = quo_q;

endmodule
